[rtl/tsuc_pkg.sv]
// shared widths, constants and the popcount helper function for the tournament score and upset count unit
// no dependencies
package tsuc_pkg;

  localparam int unsigned CountW    = 5;
  localparam int unsigned EdgeHalfW = 60;
  localparam int unsigned InDataW   = 2 * EdgeHalfW;
  localparam int unsigned WinW      = 4;
  localparam int unsigned WinsW     = 64;
  localparam int unsigned UpsetW    = 7;
  localparam int unsigned OutDataW  = 72;
  localparam int unsigned GroupW    = 16;
  localparam int unsigned GroupCntW = 5;
  localparam int unsigned MaxUpsets = 120;

  localparam logic [CountW-1:0] CountReset = 5'd16;

  // population count of 16 bits as an adder tree
  function automatic logic [GroupCntW-1:0] popcnt16(input logic [GroupW-1:0] v);
    logic [7:0][1:0] s1;
    logic [3:0][2:0] s2;
    logic [1:0][3:0] s3;
    for (int i = 0; i < 8; i++) begin
      s1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      s2[i] = 3'(s1[2*i]) + 3'(s1[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      s3[i] = 4'(s2[2*i]) + 4'(s2[2*i+1]);
    end
    return 5'(s3[0]) + 5'(s3[1]);
  endfunction

endpackage

[rtl/tournament_score_and_upset_count_unit.sv]
// top level of the tournament score and upset count unit: five-stage pipeline
// depends on tsuc_pkg
//
// usage:
// - s_axis carries one tournament per item: tdata holds the lower-triangle game
//   bitmap, bit a*(a-1)/2+b set when player a beat player b (a > b)
// - m_axis returns one result per item: per-player win counts and upset count
// - cfg writes the player count (1..16); write it only while the unit is idle
// - throughput is one item per cycle while m_axis_tready is high, each
//   stage being a registered step: input, win counts, upset compare, group
//   popcounts, final sum
// - each stage loads when empty or when the stage after it moves on, so
//   bubbles close up and items are taken while a result waits on m_axis
// - when m_axis_tready is low the output register holds and the stages fill
//   behind it; s_axis_tready drops once all five are full
// - reset empties the pipeline and sets the player count to 16; a count above
//   MAX_PLAYERS acts as MAX_PLAYERS
module tournament_score_and_upset_count_unit #(
  parameter int unsigned MAX_PLAYERS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsuc_pkg::CountW-1:0]    cfg_data_i,     // player_count
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [tsuc_pkg::InDataW-1:0]   s_axis_tdata,   // edges_low[59:0], edges_high[119:60]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [tsuc_pkg::OutDataW-1:0]  m_axis_tdata    // wins_packed[63:0], upset_count[70:64], 0
);

  localparam int unsigned NumPairs  = MAX_PLAYERS * (MAX_PLAYERS - 1) / 2;
  localparam int unsigned NumGroups = (NumPairs + tsuc_pkg::GroupW - 1) / tsuc_pkg::GroupW;
  localparam int unsigned PadW      = NumGroups * tsuc_pkg::GroupW;
  localparam logic [tsuc_pkg::CountW-1:0] MaxCount = tsuc_pkg::CountW'(MAX_PLAYERS);

  typedef logic [MAX_PLAYERS-1:0][tsuc_pkg::WinW-1:0] wins_t;

  logic [tsuc_pkg::CountW-1:0] count_q;
  logic [tsuc_pkg::CountW-1:0] count_eff;
  logic [MAX_PLAYERS-1:0]      active;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy2, rdy3, rdy4, rdy5;

  logic [NumPairs-1:0] edges1_q, edges2_q;
  wins_t               wins_d, wins2_q, wins3_q, wins4_q;
  logic [NumPairs-1:0] ups_d, ups3_q;
  logic [PadW-1:0]     ups_pad;
  logic [NumGroups-1:0][tsuc_pkg::GroupCntW-1:0] grp_d, grp4_q;
  logic [tsuc_pkg::UpsetW-1:0] upset_d, upset5_q;
  logic [tsuc_pkg::WinsW-1:0]  wins_pk_d, wins5_q;

  logic [MAX_PLAYERS-1:0][MAX_PLAYERS-1:0] beat;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= tsuc_pkg::CountReset;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign count_eff = (count_q > MaxCount) ? MaxCount : count_q;

  for (genvar p = 0; p < MAX_PLAYERS; p++) begin : g_act
    assign active[p] = tsuc_pkg::CountW'(p) < count_eff;
  end

  // flow control
  assign rdy5          = !v5_q || m_axis_tready;
  assign rdy4          = !v4_q || rdy5;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign s_axis_tready = !v1_q || rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (s_axis_tready) v1_q <= s_axis_tvalid;
      if (rdy2)          v2_q <= v1_q;
      if (rdy3)          v3_q <= v2_q;
      if (rdy4)          v4_q <= v3_q;
      if (rdy5)          v5_q <= v4_q;
    end
  end

  // win matrix and per-player win counts
  for (genvar a = 0; a < MAX_PLAYERS; a++) begin : g_row
    assign beat[a][a] = 1'b0;
    for (genvar b = 0; b < a; b++) begin : g_col
      localparam int unsigned Idx = a * (a - 1) / 2 + b;
      assign beat[a][b] = active[a] & edges1_q[Idx];
      assign beat[b][a] = active[a] & ~edges1_q[Idx];
    end
  end

  for (genvar p = 0; p < MAX_PLAYERS; p++) begin : g_wins
    logic [tsuc_pkg::GroupCntW-1:0] cnt;
    assign cnt       = tsuc_pkg::popcnt16(tsuc_pkg::GroupW'(beat[p]));
    assign wins_d[p] = cnt[tsuc_pkg::WinW-1:0];
  end

  // upset per game
  for (genvar a = 1; a < MAX_PLAYERS; a++) begin : g_ua
    for (genvar b = 0; b < a; b++) begin : g_ub
      localparam int unsigned Idx = a * (a - 1) / 2 + b;
      assign ups_d[Idx] = active[a] & (edges2_q[Idx] ? (wins2_q[a] < wins2_q[b])
                                                     : (wins2_q[a] > wins2_q[b]));
    end
  end

  // group popcounts
  assign ups_pad = PadW'(ups3_q);

  for (genvar g = 0; g < NumGroups; g++) begin : g_grp
    assign grp_d[g] = tsuc_pkg::popcnt16(ups_pad[g*tsuc_pkg::GroupW +: tsuc_pkg::GroupW]);
  end

  // final sum and packing
  always_comb begin
    upset_d   = '0;
    wins_pk_d = '0;
    for (int g = 0; g < NumGroups; g++) begin
      upset_d = upset_d + tsuc_pkg::UpsetW'(grp4_q[g]);
    end
    for (int p = 0; p < MAX_PLAYERS; p++) begin
      wins_pk_d[p*tsuc_pkg::WinW +: tsuc_pkg::WinW] = wins4_q[p];
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tready) edges1_q <= s_axis_tdata[NumPairs-1:0];
    if (rdy2) begin
      edges2_q <= edges1_q;
      wins2_q  <= wins_d;
    end
    if (rdy3) begin
      ups3_q  <= ups_d;
      wins3_q <= wins2_q;
    end
    if (rdy4) begin
      grp4_q  <= grp_d;
      wins4_q <= wins3_q;
    end
    if (rdy5) begin
      upset5_q <= upset_d;
      wins5_q  <= wins_pk_d;
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {1'b0, upset5_q, wins5_q};

endmodule

[rtl/tsuc_checker.sv]
// port-level checks for the tournament score and upset count unit, bound to the top level
// depends on tsuc_pkg and tournament_score_and_upset_count_unit
module tsuc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tsuc_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned UpsetLo = tsuc_pkg::WinsW;
  localparam int unsigned UpsetHi = tsuc_pkg::WinsW + tsuc_pkg::UpsetW - 1;

  // a stalled result stays
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // upset count within the number of games, pad bit clear
  a_upset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[UpsetHi:UpsetLo] <= tsuc_pkg::UpsetW'(tsuc_pkg::MaxUpsets))
                      && !m_axis_tdata[tsuc_pkg::OutDataW-1])
    else $error("upset count out of range");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind tournament_score_and_upset_count_unit tsuc_checker u_tsuc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
